>>> rtl/metered_valve_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Metered valve controller assertion macros
// Check macros used by the top level; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef METERED_VALVE_CONTROLLER_TOP_DEFINES_SVH
`define METERED_VALVE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define MVC_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mvc same-cycle check failed");
// next-cycle implication, disabled during reset
`define MVC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mvc next-cycle check failed");
`else
`define MVC_ASSERT_IMPL(label, ck, rn, ante, cons)
`define MVC_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

>>> rtl/mvc_pkg.sv
// ----------------------------------------------------------------------------
// Metered valve controller package
// Shared widths, codes, state encoding and inter-module structs.
// ----------------------------------------------------------------------------
package mvc_pkg;

    // counter and field widths
    localparam int CNT_W        = 32;
    localparam int PPL_W        = 16;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 4;
    localparam int ACTION_W     = 3;
    localparam int LIMIT_IN_W   = 16;
    localparam int LIMIT_ML_W   = 23;
    localparam int VOL_W        = 32;
    localparam int TOTAL_W      = 16;
    localparam int MINUTES_W    = 16;
    localparam int CAUSE_W      = 2;
    localparam int MS_SUB_W     = 16;

    // scaling constants
    localparam int ML_PER_LITER      = 1000;
    localparam int TENTHS_PER_LITER  = 10;
    localparam int ML_PER_LIMIT_UNIT = 100;
    localparam int MS_PER_MINUTE     = 60000;

    // serial divider sizing: pulses times 1000 needs 10 extra bits
    localparam int DIVIDEND_W = CNT_W + 10;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // register reset values
    localparam logic [PPL_W-1:0]  PPL_RESET      = PPL_W'(450);
    localparam logic [DATA_W-1:0] MAX_OPEN_RESET = DATA_W'(1800000);
    localparam logic [DATA_W-1:0] MAX_VOL_RESET  = DATA_W'(200000);

    // register indexes
    typedef enum logic [1:0] {
        REG_PPL      = 2'd0,
        REG_MAX_OPEN = 2'd1,
        REG_MAX_VOL  = 2'd2
    } reg_index_t;

    // input actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_PULSE      = 3'd1,
        ACT_OPEN       = 3'd2,
        ACT_OPEN_LIMIT = 3'd3,
        ACT_CLOSE      = 3'd4,
        ACT_REPORT     = 3'd5
    } action_t;

    // close causes
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_COMMAND = 2'd1,
        CAUSE_TIME    = 2'd2,
        CAUSE_VOLUME  = 2'd3
    } cause_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_VOL_LOAD,
        ST_VOL_WAIT,
        ST_TOT_LOAD,
        ST_TOT_WAIT,
        ST_DONE
    } state_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [PPL_W-1:0]  ppl;
        logic [DATA_W-1:0] max_open;
        logic [DATA_W-1:0] max_vol;
        logic              ppl_written;
    } cfg_t;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [PPL_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/metered_valve_controller_top.sv
// ----------------------------------------------------------------------------
// Metered valve controller top level
// Valve sequencer with flow metering, config registers and a serial divider.
// ----------------------------------------------------------------------------
// Each input transfer (tick, flow pulse, open, open with limit, close or
// report) yields exactly one status transfer. One item is processed at a
// time. While the valve stays open, the cycle volume goes through the
// 42-step radix-2 divider; the liters total is reconverted on the same
// divider whenever it is stale, which happens after any close and after a
// write of pulses_per_liter. A closed valve with a current total needs no
// division. The divider yields one quotient bit per clock. A finished status
// waits in an output register, so the next item is taken while that status
// is still pending. Registers sit at byte addresses 0 (pulses_per_liter), 4
// (max_open_ms) and 8 (default cycle volume limit) and should be written only
// while no item is in flight.
// ----------------------------------------------------------------------------
`include "metered_valve_controller_top_defines.svh"

module metered_valve_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mvc_pkg::ADDR_W-1:0]        paddr,
    input  logic [mvc_pkg::DATA_W-1:0]        pwdata,
    output logic [mvc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mvc_pkg::ACTION_W-1:0]      action,
    input  logic [mvc_pkg::LIMIT_IN_W-1:0]    volume_limit_hundred_ml,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valve_drive,
    output logic [mvc_pkg::VOL_W-1:0]         cycle_volume_ml,
    output logic [mvc_pkg::TOTAL_W-1:0]       total_liters_x10,
    output logic [mvc_pkg::MINUTES_W-1:0]     uptime_minutes,
    output logic [mvc_pkg::CAUSE_W-1:0]       close_cause
);
    import mvc_pkg::*;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration registers
    mvc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared serial divider
    mvc_serial_div u_serial_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and result register
    mvc_ctrl u_ctrl (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg                     (cfg),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .action                  (action),
        .volume_limit_hundred_ml (volume_limit_hundred_ml),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .valve_drive             (valve_drive),
        .cycle_volume_ml         (cycle_volume_ml),
        .total_liters_x10        (total_liters_x10),
        .uptime_minutes          (uptime_minutes),
        .close_cause             (close_cause),
        .div_req                 (div_req),
        .div_rsp                 (div_rsp)
    );

    // a closed valve reports no cycle volume
    `MVC_ASSERT_IMPL(a_closed_zero_volume, clk, rst_n, out_valid && !valve_drive, cycle_volume_ml == '0)
    // a reported close always leaves the valve closed
    `MVC_ASSERT_IMPL(a_cause_means_closed, clk, rst_n, out_valid && (close_cause != CAUSE_NONE), !valve_drive)
    // one item at a time: no transfer directly after an accepted one
    `MVC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // the divider is never restarted in the middle of a division
    `MVC_ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

>>> rtl/mvc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Metered valve controller configuration registers
// APB-style register file for pulses per liter, open time and volume limits.
// ----------------------------------------------------------------------------
module mvc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvc_pkg::ADDR_W-1:0]  paddr,
    input  logic [mvc_pkg::DATA_W-1:0]  pwdata,
    output logic [mvc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mvc_pkg::cfg_t               cfg
);
    import mvc_pkg::*;

    logic [PPL_W-1:0]  ppl_reg;
    logic [DATA_W-1:0] max_open_reg;
    logic [DATA_W-1:0] max_vol_reg;
    logic              ppl_written_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppl_reg         <= PPL_RESET;
            max_open_reg    <= MAX_OPEN_RESET;
            max_vol_reg     <= MAX_VOL_RESET;
            ppl_written_reg <= 1'b0;
        end
        else
        begin
            ppl_written_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_PPL:
                    begin
                        ppl_reg         <= pwdata[PPL_W-1:0];
                        ppl_written_reg <= 1'b1;
                    end
                    REG_MAX_OPEN: max_open_reg <= pwdata;
                    REG_MAX_VOL:  max_vol_reg  <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_PPL:      prdata = DATA_W'(ppl_reg);
            REG_MAX_OPEN: prdata = max_open_reg;
            REG_MAX_VOL:  prdata = max_vol_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.ppl         = ppl_reg;
    assign cfg.max_open    = max_open_reg;
    assign cfg.max_vol     = max_vol_reg;
    assign cfg.ppl_written = ppl_written_reg;

endmodule

>>> rtl/mvc_serial_div.sv
// ----------------------------------------------------------------------------
// Metered valve controller serial divider
// Radix-2 restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module mvc_serial_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mvc_pkg::div_req_t req,
    output mvc_pkg::div_rsp_t rsp
);
    import mvc_pkg::*;

    logic [DIVIDEND_W-1:0] shift_reg, shift_next;
    logic [PPL_W-1:0]      rem_reg, rem_next;
    logic [PPL_W-1:0]      divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PPL_W:0]        trial;
    logic [PPL_W:0]        diff;
    logic                  fits;

    // one restoring step
    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            shift_next   = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            cnt_next     = DIV_CNT_W'(DIVIDEND_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[PPL_W-1:0] : trial[PPL_W-1:0];
            shift_next = {shift_reg[DIVIDEND_W-2:0], fits};
            cnt_next   = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = shift_reg;

endmodule

>>> rtl/mvc_ctrl.sv
// ----------------------------------------------------------------------------
// Metered valve controller sequencer
// Applies each action, runs the time and volume checks and the total
// conversion on the shared divider, and holds the result register.
// ----------------------------------------------------------------------------
module mvc_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvc_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mvc_pkg::ACTION_W-1:0]      action,
    input  logic [mvc_pkg::LIMIT_IN_W-1:0]    volume_limit_hundred_ml,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valve_drive,
    output logic [mvc_pkg::VOL_W-1:0]         cycle_volume_ml,
    output logic [mvc_pkg::TOTAL_W-1:0]       total_liters_x10,
    output logic [mvc_pkg::MINUTES_W-1:0]     uptime_minutes,
    output logic [mvc_pkg::CAUSE_W-1:0]       close_cause,
    output mvc_pkg::div_req_t                 div_req,
    input  mvc_pkg::div_rsp_t                 div_rsp
);
    import mvc_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       pulse_count_reg, pulse_count_next;
    logic [CNT_W-1:0]       cycle_start_reg, cycle_start_next;
    logic [CNT_W-1:0]       opened_at_reg, opened_at_next;
    logic [CNT_W-1:0]       ms_clock_reg, ms_clock_next;
    logic [MS_SUB_W-1:0]    ms_sub_reg, ms_sub_next;
    logic [MINUTES_W-1:0]   minutes_reg, minutes_next;
    logic [LIMIT_ML_W-1:0]  cycle_limit_reg, cycle_limit_next;
    logic                   valve_open_reg, valve_open_next;
    logic [CNT_W-1:0]       committed_reg, committed_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   total_dirty_reg, total_dirty_next;
    cause_t                 cause_reg, cause_next;
    logic [VOL_W-1:0]       vol_reg, vol_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_valve_reg;
    logic [VOL_W-1:0]       out_vol_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic [MINUTES_W-1:0]   out_minutes_reg;
    cause_t                 out_cause_reg;

    logic                   accept;
    logic                   load_out;
    logic [CNT_W-1:0]       cycle_pulses;
    logic [CNT_W-1:0]       elapsed;
    logic                   time_close;
    logic [VOL_W-1:0]       vol_sat;
    logic [DATA_W-1:0]      vol_limit;
    logic                   vol_close;
    logic [TOTAL_W-1:0]     total_sat;
    logic [PPL_W-1:0]       divisor;

    // shared arithmetic
    assign cycle_pulses = pulse_count_reg - cycle_start_reg;
    assign elapsed      = ms_clock_reg - opened_at_reg;
    assign time_close   = valve_open_reg && (elapsed > CNT_W'(cfg.max_open));
    assign divisor      = (cfg.ppl == '0) ? PPL_W'(1) : cfg.ppl;
    assign vol_sat      = (div_rsp.quotient > DIVIDEND_W'({VOL_W{1'b1}}))
                          ? {VOL_W{1'b1}} : div_rsp.quotient[VOL_W-1:0];
    assign vol_limit    = (cycle_limit_reg != '0) ? DATA_W'(cycle_limit_reg)
                                                  : cfg.max_vol;
    assign vol_close    = (vol_sat >= vol_limit);
    assign total_sat    = (div_rsp.quotient > DIVIDEND_W'({TOTAL_W{1'b1}}))
                          ? {TOTAL_W{1'b1}} : div_rsp.quotient[TOTAL_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_TIME;
            ST_TIME:
                priority if (valve_open_reg && !time_close)
                    state_next = ST_VOL_LOAD;
                else if (total_dirty_reg || time_close)
                    state_next = ST_TOT_LOAD;
                else
                    state_next = ST_DONE;
            ST_VOL_LOAD:
                state_next = ST_VOL_WAIT;
            ST_VOL_WAIT:
                if (div_rsp.done)
                    state_next = (total_dirty_reg || vol_close) ? ST_TOT_LOAD : ST_DONE;
            ST_TOT_LOAD:
                state_next = ST_TOT_WAIT;
            ST_TOT_WAIT:
                if (div_rsp.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready         = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.divisor  = divisor;
        div_req.dividend = DIVIDEND_W'(cycle_pulses) * DIVIDEND_W'(ML_PER_LITER);
        unique case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_VOL_LOAD: div_req.start = 1'b1;
            ST_TOT_LOAD:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(committed_reg)
                                   * DIVIDEND_W'(TENTHS_PER_LITER);
            end
            ST_DONE:     load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign accept = in_valid && in_ready;

    // datapath next values
    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        cycle_start_next = cycle_start_reg;
        opened_at_next   = opened_at_reg;
        ms_clock_next    = ms_clock_reg;
        ms_sub_next      = ms_sub_reg;
        minutes_next     = minutes_reg;
        cycle_limit_next = cycle_limit_reg;
        valve_open_next  = valve_open_reg;
        committed_next   = committed_reg;
        total_next       = total_reg;
        total_dirty_next = total_dirty_reg;
        cause_next       = cause_reg;
        vol_next         = vol_reg;

        // apply the action
        if (accept)
        begin
            cause_next = CAUSE_NONE;
            unique case (action)
                ACT_TICK:
                begin
                    if (ms_clock_reg == {CNT_W{1'b1}})
                    begin
                        ms_clock_next = '0;
                        ms_sub_next   = '0;
                        minutes_next  = '0;
                    end
                    else
                    begin
                        ms_clock_next = ms_clock_reg + CNT_W'(1);
                        if (ms_sub_reg == MS_SUB_W'(MS_PER_MINUTE - 1))
                        begin
                            ms_sub_next  = '0;
                            minutes_next = minutes_reg + MINUTES_W'(1);
                        end
                        else
                            ms_sub_next = ms_sub_reg + MS_SUB_W'(1);
                    end
                end
                ACT_PULSE:
                    pulse_count_next = pulse_count_reg + CNT_W'(1);
                ACT_OPEN:
                begin
                    cycle_start_next = pulse_count_reg;
                    cycle_limit_next = '0;
                    opened_at_next   = ms_clock_reg;
                    valve_open_next  = 1'b1;
                end
                ACT_OPEN_LIMIT:
                begin
                    cycle_start_next = pulse_count_reg;
                    cycle_limit_next = LIMIT_ML_W'(volume_limit_hundred_ml)
                                       * LIMIT_ML_W'(ML_PER_LIMIT_UNIT);
                    opened_at_next   = ms_clock_reg;
                    valve_open_next  = 1'b1;
                end
                ACT_CLOSE:
                    if (valve_open_reg)
                    begin
                        committed_next   = committed_reg + cycle_pulses;
                        valve_open_next  = 1'b0;
                        total_dirty_next = 1'b1;
                        cause_next       = CAUSE_COMMAND;
                    end
                default: ;
            endcase
        end

        // open time limit
        if (state_reg == ST_TIME && time_close)
        begin
            committed_next   = committed_reg + cycle_pulses;
            valve_open_next  = 1'b0;
            total_dirty_next = 1'b1;
            cause_next       = CAUSE_TIME;
        end

        // volume limit
        if (state_reg == ST_VOL_WAIT && div_rsp.done)
        begin
            if (vol_close)
            begin
                committed_next   = committed_reg + cycle_pulses;
                valve_open_next  = 1'b0;
                total_dirty_next = 1'b1;
                cause_next       = CAUSE_VOLUME;
            end
            else
                vol_next = vol_sat;
        end

        // total conversion
        if (state_reg == ST_TOT_WAIT && div_rsp.done)
        begin
            total_next       = total_sat;
            total_dirty_next = 1'b0;
        end

        // a new pulses per liter value invalidates the total
        if (cfg.ppl_written)
            total_dirty_next = 1'b1;
    end

    // result register handshake
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pulse_count_reg <= '0;
            cycle_start_reg <= '0;
            opened_at_reg   <= '0;
            ms_clock_reg    <= '0;
            ms_sub_reg      <= '0;
            minutes_reg     <= '0;
            cycle_limit_reg <= '0;
            valve_open_reg  <= 1'b0;
            committed_reg   <= '0;
            total_reg       <= '0;
            total_dirty_reg <= 1'b0;
            cause_reg       <= CAUSE_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pulse_count_reg <= pulse_count_next;
            cycle_start_reg <= cycle_start_next;
            opened_at_reg   <= opened_at_next;
            ms_clock_reg    <= ms_clock_next;
            ms_sub_reg      <= ms_sub_next;
            minutes_reg     <= minutes_next;
            cycle_limit_reg <= cycle_limit_next;
            valve_open_reg  <= valve_open_next;
            committed_reg   <= committed_next;
            total_reg       <= total_next;
            total_dirty_reg <= total_dirty_next;
            cause_reg       <= cause_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vol_reg <= vol_next;
        if (load_out)
        begin
            out_valve_reg   <= valve_open_reg;
            out_vol_reg     <= valve_open_reg ? vol_reg : '0;
            out_total_reg   <= total_reg;
            out_minutes_reg <= minutes_reg;
            out_cause_reg   <= cause_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign valve_drive      = out_valve_reg;
    assign cycle_volume_ml  = out_vol_reg;
    assign total_liters_x10 = out_total_reg;
    assign uptime_minutes   = out_minutes_reg;
    assign close_cause      = out_cause_reg;

endmodule

>>> sim/tb_metered_valve_controller_top.sv
// ----------------------------------------------------------------------------
// Metered valve controller testbench
// Sends ticks, flow pulses and valve commands to the controller and checks each
// status transfer against an in-house predictor. A directed table runs first.
// Random phases follow, each with its own register settings.
// ----------------------------------------------------------------------------
module tb_metered_valve_controller_top;

    import mvc_pkg::*;

    // run sizing
    localparam int          PHASES          = 6;
    localparam int          PHASE_ITEMS     = 170;
    localparam int          SETTLE_CYCLES   = 150;
    localparam int          HOLD_CYCLES     = 500;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          MAX_REPORTS     = 10;

    // action codes the block does not define, handled like a report
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    // one status transfer
    typedef struct packed {
        logic                 valve;
        logic [VOL_W-1:0]     vol;
        logic [TOTAL_W-1:0]   total;
        logic [MINUTES_W-1:0] minutes;
        cause_t               cause;
    } status_t;

    // one row of the directed table: a register write or an item
    typedef struct {
        bit                    is_cfg;
        reg_index_t            idx;
        logic [DATA_W-1:0]     value;
        logic [ACTION_W-1:0]   act;
        logic [LIMIT_IN_W-1:0] lim;
        bit                    known;
        status_t               want;
    } plan_row_t;

    localparam status_t CLOSED_CLEAN = '{valve: 1'b0, vol: '0, total: '0, minutes: '0,
                                         cause: CAUSE_NONE};
    localparam status_t OPEN_FRESH   = '{valve: 1'b1, vol: '0, total: '0, minutes: '0,
                                         cause: CAUSE_NONE};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_ready;
    logic [ACTION_W-1:0]    action;
    logic [LIMIT_IN_W-1:0]  volume_limit_hundred_ml;
    logic                   out_valid;
    logic                   out_ready;
    logic                   valve_drive;
    logic [VOL_W-1:0]       cycle_volume_ml;
    logic [TOTAL_W-1:0]     total_liters_x10;
    logic [MINUTES_W-1:0]   uptime_minutes;
    logic [CAUSE_W-1:0]     close_cause;

    // typed expectation travelling with the payload
    logic                   known_en;
    status_t                known_status;

    // predictor state and its copy of the registers
    logic [CNT_W-1:0]       pulse_cnt    = '0;
    logic [CNT_W-1:0]       cycle_start  = '0;
    logic [CNT_W-1:0]       opened_ms    = '0;
    logic [CNT_W-1:0]       ms_now       = '0;
    logic [LIMIT_ML_W-1:0]  limit_ml     = '0;
    logic                   valve_open   = 1'b0;
    logic [CNT_W-1:0]       committed    = '0;
    logic [PPL_W-1:0]       cfg_ppl      = PPL_RESET;
    logic [DATA_W-1:0]      cfg_max_open = MAX_OPEN_RESET;
    logic [DATA_W-1:0]      cfg_max_vol  = MAX_VOL_RESET;

    status_t                pending_status[$];
    plan_row_t              plan[$];
    int unsigned            errors       = 0;
    int unsigned            results_seen = 0;
    int unsigned            items_sent   = 0;
    int unsigned            quiet_cycles = 0;
    bit                     in_idle      = 1'b1;
    bit                     out_idle     = 1'b1;
    bit                     hold_req     = 1'b0;
    bit                     dirty        = 1'b0;

    metered_valve_controller_top u_top (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .action                  (action),
        .volume_limit_hundred_ml (volume_limit_hundred_ml),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .valve_drive             (valve_drive),
        .cycle_volume_ml         (cycle_volume_ml),
        .total_liters_x10        (total_liters_x10),
        .uptime_minutes          (uptime_minutes),
        .close_cause             (close_cause)
    );

    always #5 clk = ~clk;

    // count times scale over the meter rate, truncated and capped
    function automatic logic [63:0] to_units(logic [CNT_W-1:0] count, int unsigned scale,
                                             logic [63:0] cap);
        logic [63:0] div;
        logic [63:0] q;
        div = (cfg_ppl == '0) ? 64'd1 : 64'(cfg_ppl);
        q   = (64'(count) * 64'(scale)) / div;
        return (q > cap) ? cap : q;
    endfunction

    function automatic logic [63:0] cycle_ml();
        return to_units(pulse_cnt - cycle_start, ML_PER_LITER, 64'hFFFF_FFFF);
    endfunction

    function automatic void start_cycle(logic [LIMIT_ML_W-1:0] lim_ml);
        cycle_start = pulse_cnt;
        limit_ml    = lim_ml;
        opened_ms   = ms_now;
        valve_open  = 1'b1;
    endfunction

    // fold the cycle pulses into the running total
    function automatic void end_cycle();
        committed  = committed + (pulse_cnt - cycle_start);
        valve_open = 1'b0;
    endfunction

    // apply one item to the predicted valve state, return its status
    function automatic status_t advance_valve(logic [ACTION_W-1:0] act,
                                              logic [LIMIT_IN_W-1:0] lim);
        status_t     s;
        logic [63:0] cap_ml;
        s       = CLOSED_CLEAN;
        case (act)
            ACT_TICK:
            begin
                ms_now = ms_now + 1'b1;
            end
            ACT_PULSE:
            begin
                pulse_cnt = pulse_cnt + 1'b1;
            end
            ACT_OPEN:
            begin
                start_cycle('0);
            end
            ACT_OPEN_LIMIT:
            begin
                start_cycle(LIMIT_ML_W'(32'(lim) * ML_PER_LIMIT_UNIT));
            end
            ACT_CLOSE:
            begin
                if (valve_open)
                begin
                    end_cycle();
                    s.cause = CAUSE_COMMAND;
                end
            end
            default:
            begin
            end
        endcase
        // time limit is checked ahead of the volume limit
        if (valve_open && (CNT_W'(ms_now - opened_ms) > cfg_max_open))
        begin
            end_cycle();
            s.cause = CAUSE_TIME;
        end
        if (valve_open)
        begin
            cap_ml = (limit_ml != '0) ? 64'(limit_ml) : 64'(cfg_max_vol);
            if (cycle_ml() >= cap_ml)
            begin
                end_cycle();
                s.cause = CAUSE_VOLUME;
            end
        end
        s.valve   = valve_open;
        s.vol     = valve_open ? VOL_W'(cycle_ml()) : '0;
        s.total   = TOTAL_W'(to_units(committed, TENTHS_PER_LITER, 64'hFFFF));
        s.minutes = MINUTES_W'(ms_now / MS_PER_MINUTE);
        return s;
    endfunction

    function automatic plan_row_t cfg_row(reg_index_t idx, logic [DATA_W-1:0] value);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        r.act    = ACT_REPORT;
        r.lim    = '0;
        r.known  = 1'b0;
        r.want   = CLOSED_CLEAN;
        return r;
    endfunction

    function automatic plan_row_t known_row(logic [ACTION_W-1:0] act,
                                            logic [LIMIT_IN_W-1:0] lim, status_t want);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = REG_PPL;
        r.value  = '0;
        r.act    = act;
        r.lim    = lim;
        r.known  = 1'b1;
        r.want   = want;
        return r;
    endfunction

    function automatic plan_row_t act_row(logic [ACTION_W-1:0] act,
                                          logic [LIMIT_IN_W-1:0] lim);
        plan_row_t r;
        r       = known_row(act, lim, CLOSED_CLEAN);
        r.known = 1'b0;
        return r;
    endfunction

    // idle stretch: mostly short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LIMIT_IN_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 70)
            return LIMIT_IN_W'($urandom_range(1, 30));
        if (r < 95)
            return LIMIT_IN_W'($urandom);
        return '1;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // offer one item and hold it until the transfer
    task automatic send_item(logic [ACTION_W-1:0] act, logic [LIMIT_IN_W-1:0] lim,
                             bit known, status_t want);
        if (in_idle && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat (idle_gap()) @(posedge clk);
        end
        in_valid                <= 1'b1;
        action                  <= act;
        volume_limit_hundred_ml <= lim;
        known_en                <= known;
        known_status            <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        dirty = 1'b1;
    endtask

    task automatic offer(logic [ACTION_W-1:0] act, logic [LIMIT_IN_W-1:0] lim);
        send_item(act, lim, 1'b0, CLOSED_CLEAN);
    endtask

    // stop offering, wait for every status, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        if (dirty)
        begin
            @(posedge clk);
            while (pending_status.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            dirty = 1'b0;
        end
    endtask

    // register write: setup cycle, access cycle, then back to idle
    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PPL:      cfg_ppl      = value[PPL_W-1:0];
            REG_MAX_OPEN: cfg_max_open = value;
            REG_MAX_VOL:  cfg_max_vol  = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(logic [PPL_W-1:0] ppl, logic [DATA_W-1:0] max_open,
                                 logic [DATA_W-1:0] max_vol);
        settle();
        write_reg(REG_PPL, DATA_W'(ppl));
        write_reg(REG_MAX_OPEN, max_open);
        write_reg(REG_MAX_VOL, max_vol);
    endtask

    // predict on every input transfer
    always @(posedge clk)
    begin : predict_status
        status_t next_status;
        if (rst_n && in_valid && in_ready)
        begin
            next_status = advance_valve(action, volume_limit_hundred_ml);
            pending_status.push_back(known_en ? known_status : next_status);
        end
    end

    // compare every output transfer with the oldest prediction
    always @(posedge clk)
    begin : check_status
        status_t got;
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{valve: valve_drive, vol: cycle_volume_ml, total: total_liters_x10,
                    minutes: uptime_minutes, cause: cause_t'(close_cause)};
            if (pending_status.size() == 0)
            begin
                flag_error($sformatf("status %0d arrived with nothing pending", results_seen));
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.valve !== want.valve)
                    flag_error($sformatf("status %0d valve_drive: expected %0d, got %0d",
                                         results_seen, want.valve, got.valve));
                if (got.vol !== want.vol)
                    flag_error($sformatf("status %0d cycle_volume_ml: expected %0d, got %0d",
                                         results_seen, want.vol, got.vol));
                if (got.total !== want.total)
                    flag_error($sformatf("status %0d total_liters_x10: expected %0d, got %0d",
                                         results_seen, want.total, got.total));
                if (got.minutes !== want.minutes)
                    flag_error($sformatf("status %0d uptime_minutes: expected %0d, got %0d",
                                         results_seen, want.minutes, got.minutes));
                if (got.cause !== want.cause)
                    flag_error($sformatf("status %0d close_cause: expected %0d, got %0d",
                                         results_seen, want.cause, got.cause));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // status receiver with random stalls and one long hold-off
    initial
    begin : status_sink
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (out_idle && $urandom_range(0, 99) < 30)
            begin
                out_ready <= 1'b0;
                repeat (idle_gap()) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned phase_end;
        int unsigned body;
        int unsigned pick;
        bit          held;
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        in_valid                <= 1'b0;
        action                  <= ACT_REPORT;
        volume_limit_hundred_ml <= '0;
        known_en                <= 1'b0;
        known_status            <= CLOSED_CLEAN;
        held                    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        plan = '{
            known_row(ACT_REPORT, 16'h0000, CLOSED_CLEAN),
            known_row(ACT_CLOSE, 16'hFFFF, CLOSED_CLEAN),        // close while closed
            known_row(ACT_SPARE_6, 16'h5A5A, CLOSED_CLEAN),
            known_row(ACT_SPARE_7, 16'hA5A5, CLOSED_CLEAN),
            known_row(ACT_TICK, 16'h0000, CLOSED_CLEAN),
            known_row(ACT_PULSE, 16'h0000, CLOSED_CLEAN),        // pulse outside any cycle
            known_row(ACT_OPEN, 16'h0000, OPEN_FRESH),
            act_row(ACT_PULSE, 16'h0000),
            known_row(ACT_OPEN_LIMIT, 16'hFFFF, OPEN_FRESH),     // reopen drops the pulse
            act_row(ACT_PULSE, 16'h0000),
            act_row(ACT_CLOSE, 16'h0000),
            // zero meter rate, zero open time, zero default volume
            cfg_row(REG_PPL, 32'd0),
            cfg_row(REG_MAX_OPEN, 32'd0),
            cfg_row(REG_MAX_VOL, 32'd0),
            act_row(ACT_OPEN, 16'h0000),                         // shuts on its own item
            act_row(ACT_OPEN_LIMIT, 16'h0001),
            act_row(ACT_TICK, 16'h0000),                         // first tick trips time
            act_row(ACT_OPEN_LIMIT, 16'h0000),                   // falls back to default
            // widest settings
            cfg_row(REG_PPL, 32'h0000_FFFF),
            cfg_row(REG_MAX_OPEN, 32'hFFFF_FFFF),
            cfg_row(REG_MAX_VOL, 32'hFFFF_FFFF),
            act_row(ACT_OPEN_LIMIT, 16'h0001),
            act_row(ACT_PULSE, 16'h0000),
            act_row(ACT_TICK, 16'h0000),
            act_row(ACT_REPORT, 16'h0000),
            act_row(ACT_CLOSE, 16'h0000),
            // one liter per pulse
            cfg_row(REG_PPL, 32'd1),
            cfg_row(REG_MAX_OPEN, 32'd1),
            cfg_row(REG_MAX_VOL, 32'd1000),
            act_row(ACT_OPEN_LIMIT, 16'h0000),
            act_row(ACT_PULSE, 16'h0000),                        // volume reached
            act_row(ACT_OPEN, 16'h0000),
            act_row(ACT_TICK, 16'h0000),
            act_row(ACT_TICK, 16'h0000),                         // open time exceeded
            act_row(ACT_OPEN, 16'h0000),
            // both limits on one item, time wins
            cfg_row(REG_MAX_OPEN, 32'd0),
            cfg_row(REG_MAX_VOL, 32'd0),
            act_row(ACT_TICK, 16'h0000)
        };
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                send_item(plan[i].act, plan[i].lim, plan[i].known, plan[i].want);
            end
        end

        // random phases, each under its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            in_idle  = (phase != 2);
            out_idle = (phase != 3);
            case (phase)
                0: load_settings(16'd10, 32'd30, 32'd1500);
                1: load_settings(16'd1, 32'd0, 32'd0);
                2: load_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: load_settings(PPL_W'($urandom_range(1, 300)), $urandom_range(1, 100),
                                 $urandom_range(1, 20000));
                4: load_settings(16'd0, $urandom_range(0, 60), $urandom_range(0, 5000));
                default: load_settings(PPL_W'($urandom), $urandom, $urandom);
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                // receiver holds off while items keep coming
                if (phase == 0 && !held && items_sent + 100 >= phase_end)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    // one watering cycle with random content
                    if ($urandom_range(0, 1) == 0)
                        offer(ACT_OPEN, LIMIT_IN_W'($urandom));
                    else
                        offer(ACT_OPEN_LIMIT, pick_limit());
                    body = $urandom_range(0, 16);
                    repeat (body)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 5)
                            offer(ACT_PULSE, LIMIT_IN_W'($urandom));
                        else if (pick < 9)
                            offer(ACT_TICK, LIMIT_IN_W'($urandom));
                        else
                            offer(ACT_REPORT, LIMIT_IN_W'($urandom));
                    end
                    if ($urandom_range(0, 99) < 70)
                        offer(ACT_CLOSE, LIMIT_IN_W'($urandom));
                end
                else
                begin
                    offer(ACTION_W'($urandom_range(0, 7)), LIMIT_IN_W'($urandom));
                end
            end
        end

        settle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
